// File: sv/crs_pkg.sv
// Shared types, widths and constants of the Catmull-Rom path sampler.
// No dependencies; every other file but crs_check references it by scoped names.
package crs_pkg;

  localparam int COORD_W      = 16;
  localparam int HEAD_W       = 16;
  localparam int STEPS_W      = 5;
  localparam int MAX_STEPS    = 16;
  localparam int STEPS_RESET  = 10;
  localparam int K_W          = 4;
  localparam int R2_W         = 9;
  localparam int COEF_W       = 20;
  localparam int FAC_W        = 13;
  localparam int PROD_W       = COEF_W + FAC_W + 1;
  localparam int ACC_W        = 36;
  localparam int DEN_W        = FAC_W + 1;
  localparam int MAG_W        = 33;
  localparam int REM_W        = DEN_W + 1;
  localparam int CNT_W        = 6;
  localparam int NORM_W       = 30;
  localparam int CORD_W       = 33;
  localparam int ANG_W        = 25;
  localparam int CORDIC_STEPS = 20;
  localparam int TERMS        = 14;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 25'sd3294199;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 25'sd1647099;
  localparam logic signed [ANG_W-1:0] ANG_ROUND   = 25'sd128;

  typedef enum logic [1:0] {ACC_X, ACC_Z, ACC_DX, ACC_DZ} acc_sel_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] q1;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  typedef struct packed {
    coef_t x;
    coef_t z;
  } coef_xz_t;

  typedef struct packed {
    logic [FAC_W-1:0] r3;
    logic [FAC_W-1:0] kr2;
    logic [FAC_W-1:0] k2r;
    logic [FAC_W-1:0] k3;
    logic [FAC_W-1:0] r2;
    logic [FAC_W-1:0] kr_x2;
    logic [FAC_W-1:0] k2_x3;
  } fac_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] nx;
    logic signed [ACC_W-1:0] nz;
    logic signed [ACC_W-1:0] dx;
    logic signed [ACC_W-1:0] dz;
  } mac_res_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 25'sd823550;
      5'd1:    v = 25'sd486170;
      5'd2:    v = 25'sd256879;
      5'd3:    v = 25'sd130396;
      5'd4:    v = 25'sd65451;
      5'd5:    v = 25'sd32757;
      5'd6:    v = 25'sd16383;
      5'd7:    v = 25'sd8192;
      5'd8:    v = 25'sd4096;
      5'd9:    v = 25'sd2048;
      5'd10:   v = 25'sd1024;
      5'd11:   v = 25'sd512;
      5'd12:   v = 25'sd256;
      5'd13:   v = 25'sd128;
      5'd14:   v = 25'sd64;
      5'd15:   v = 25'sd32;
      5'd16:   v = 25'sd16;
      5'd17:   v = 25'sd8;
      5'd18:   v = 25'sd4;
      5'd19:   v = 25'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/crs_ifs.sv
// Valid/ready channel interfaces: waypoint input, sample output, config write.
// Depends on crs_pkg for field widths.
interface crs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [crs_pkg::COORD_W-1:0]   point_x;
  logic signed [crs_pkg::COORD_W-1:0]   point_z;
  logic signed [crs_pkg::HEAD_W-1:0]    heading_in;
  logic                                 path_end;
  modport source(output valid, point_x, point_z, heading_in, path_end, input ready);
  modport sink(input valid, point_x, point_z, heading_in, path_end, output ready);
endinterface

interface crs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [crs_pkg::COORD_W-1:0]   out_x;
  logic signed [crs_pkg::COORD_W-1:0]   out_z;
  logic signed [crs_pkg::HEAD_W-1:0]    out_heading;
  logic                                 run_last;
  modport source(output valid, out_x, out_z, out_heading, run_last, input ready);
  modport sink(input valid, out_x, out_z, out_heading, run_last, output ready);
endinterface

interface crs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [crs_pkg::STEPS_W-1:0]          segment_steps;
  modport source(output valid, segment_steps, input ready);
  modport sink(input valid, segment_steps, output ready);
endinterface

// File: sv/catmull_rom_path_spline.sv
// Catmull-Rom path sampler top level: waypoint window, sequencer, output register.
// Depends on crs_pkg, crs_ifs, crs_mac, crs_div, crs_atan.
// Waypoints stream in one per transfer; points without path_end among the first three
// are stored in the window. From the fourth point on, each waypoint produces one to three
// segments of segment_steps samples (0 acts as 1, above 16 as 16). For each sample the
// shared multiplier builds the numerators, then the bit-serial divider runs alongside
// the normalizer and 20-step CORDIC (longest for a short derivative vector), then the
// output transfer follows; the first sample of a segment first builds the coefficients.
// Short paths (path_end before the fourth point) are echoed back point by point. The
// input is not ready while an item is in work.
module catmull_rom_path_spline (
  input logic      clk,
  input logic      rst_n,
  crs_in_if.sink   in_ch,
  crs_out_if.source out_ch,
  crs_cfg_if.sink  cfg_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ECHO = 6'b000010,
    ST_SEG  = 6'b000100,
    ST_MAC  = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_HOLD = 6'b100000
  } st_t;

  localparam logic [1:0] SEG_HEAD = 2'd0;
  localparam logic [1:0] SEG_MID  = 2'd1;
  localparam logic [1:0] SEG_TAIL = 2'd2;

  st_t                                state_r, state_nxt;
  logic [crs_pkg::STEPS_W-1:0]        steps_r;
  logic [2:0]                         ps_r;
  logic signed [crs_pkg::COORD_W-1:0] wx_r [3];
  logic signed [crs_pkg::COORD_W-1:0] wz_r [3];
  logic signed [crs_pkg::HEAD_W-1:0]  wh_r [3];
  logic signed [crs_pkg::COORD_W-1:0] nx_r, nz_r;
  logic signed [crs_pkg::HEAD_W-1:0]  nh_r;
  logic                               nend_r;
  logic [crs_pkg::STEPS_W-1:0]        r_r;
  logic [crs_pkg::R2_W-1:0]           r2_r;
  logic [crs_pkg::FAC_W-1:0]          r3_r;
  logic [1:0]                         s_r, s_last_r, e_r, ep_r;
  logic [crs_pkg::K_W-1:0]            k_r;
  logic                               echo_r;
  crs_pkg::coef_xz_t                  coef_r;
  logic signed [crs_pkg::COORD_W-1:0] ox_r, oz_r;
  logic signed [crs_pkg::HEAD_W-1:0]  oh_r;
  logic                               ol_r;

  logic in_valid_w, in_ready_w, out_valid_w, out_ready_w, out_last_w, cfg_valid_w, cfg_ready_w;
  logic in_fire, out_fire, start_spline, k_end, samp_last;
  logic [crs_pkg::STEPS_W-1:0]        rc;
  logic [2*crs_pkg::STEPS_W-1:0]      r2_full;
  logic [crs_pkg::R2_W+crs_pkg::STEPS_W-1:0] r3_full;
  logic signed [crs_pkg::COORD_W-1:0] qx [4];
  logic signed [crs_pkg::COORD_W-1:0] qz [4];
  logic [7:0]                         k2;
  crs_pkg::fac_t                      fac;
  crs_pkg::mac_res_t                  mres;
  logic                               mac_done, div_done, at_done;
  logic signed [crs_pkg::COORD_W-1:0] dq_x, dq_z;
  logic signed [crs_pkg::HEAD_W-1:0]  at_head;

  function automatic crs_pkg::coef_t mk_coef(
    input logic signed [crs_pkg::COORD_W-1:0] p0, p1, p2, p3
  );
    crs_pkg::coef_t c;
    logic signed [crs_pkg::COEF_W-1:0] e0, e1, e2, e3;
    e0   = crs_pkg::COEF_W'(p0);
    e1   = crs_pkg::COEF_W'(p1);
    e2   = crs_pkg::COEF_W'(p2);
    e3   = crs_pkg::COEF_W'(p3);
    c.q1 = e1;
    c.a  = e2 - e0;
    c.b  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c.c  = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
    return c;
  endfunction

  assign in_valid_w    = in_ch.valid;
  assign in_ready_w    = (state_r == ST_IDLE);
  assign in_ch.ready   = in_ready_w;
  assign out_valid_w   = (state_r == ST_HOLD);
  assign out_ready_w   = out_ch.ready;
  assign out_last_w    = ol_r;
  assign cfg_valid_w   = cfg_ch.valid;
  assign cfg_ready_w   = 1'b1;
  assign cfg_ch.ready  = cfg_ready_w;
  assign out_ch.valid  = out_valid_w;
  assign out_ch.out_x  = ox_r;
  assign out_ch.out_z  = oz_r;
  assign out_ch.out_heading = oh_r;
  assign out_ch.run_last    = ol_r;

  assign in_fire      = in_valid_w & in_ready_w;
  assign out_fire     = out_valid_w & out_ready_w;
  assign start_spline = !((ps_r < 3'd3) && !in_ch.path_end);
  assign k_end        = ({1'b0, k_r} == (r_r - 1'b1));
  assign samp_last    = k_end && (s_r == s_last_r);

  always_comb begin
    if (steps_r == '0)                                     rc = 5'd1;
    else if (steps_r > crs_pkg::STEPS_W'(crs_pkg::MAX_STEPS)) rc = crs_pkg::STEPS_W'(crs_pkg::MAX_STEPS);
    else                                                   rc = steps_r;
    r2_full = rc * rc;
    r3_full = r2_full[crs_pkg::R2_W-1:0] * rc;
  end

  always_comb begin
    k2        = k_r * k_r;
    fac.r3    = r3_r;
    fac.r2    = crs_pkg::FAC_W'(r2_r);
    fac.kr2   = crs_pkg::FAC_W'(k_r) * crs_pkg::FAC_W'(r2_r);
    fac.k2r   = crs_pkg::FAC_W'(k2) * crs_pkg::FAC_W'(r_r);
    fac.k3    = crs_pkg::FAC_W'(k2) * crs_pkg::FAC_W'(k_r);
    fac.kr_x2 = (crs_pkg::FAC_W'(k_r) * crs_pkg::FAC_W'(r_r)) << 1;
    fac.k2_x3 = crs_pkg::FAC_W'({k2, 1'b0}) + crs_pkg::FAC_W'(k2);
  end

  always_comb begin
    case (s_r)
      SEG_HEAD: begin
        qx[0] = wx_r[0]; qx[1] = wx_r[0]; qx[2] = wx_r[1]; qx[3] = wx_r[2];
        qz[0] = wz_r[0]; qz[1] = wz_r[0]; qz[2] = wz_r[1]; qz[3] = wz_r[2];
      end
      SEG_MID: begin
        qx[0] = wx_r[0]; qx[1] = wx_r[1]; qx[2] = wx_r[2]; qx[3] = nx_r;
        qz[0] = wz_r[0]; qz[1] = wz_r[1]; qz[2] = wz_r[2]; qz[3] = nz_r;
      end
      default: begin
        qx[0] = wx_r[1]; qx[1] = wx_r[2]; qx[2] = nx_r; qx[3] = nx_r;
        qz[0] = wz_r[1]; qz[1] = wz_r[2]; qz[2] = nz_r; qz[3] = nz_r;
      end
    endcase
  end

  crs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (state_r == ST_MAC),
    .coef  (coef_r),
    .fac   (fac),
    .done  (mac_done),
    .res   (mres)
  );

  crs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (state_r == ST_WAIT),
    .num_x (mres.nx),
    .num_z (mres.nz),
    .den   ({r3_r, 1'b0}),
    .done  (div_done),
    .q_x   (dq_x),
    .q_z   (dq_z)
  );

  crs_atan u_atan (
    .clk     (clk),
    .rst_n   (rst_n),
    .run     (state_r == ST_WAIT),
    .vx      (mres.dx),
    .vy      (-mres.dz),
    .done    (at_done),
    .heading (at_head)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire && start_spline) state_nxt = (ps_r < 3'd3) ? ST_ECHO : ST_SEG;
      ST_ECHO: state_nxt = ST_HOLD;
      ST_SEG:  state_nxt = ST_MAC;
      ST_MAC:  if (mac_done) state_nxt = ST_WAIT;
      ST_WAIT: if (div_done && at_done) state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_fire) begin
          if (ol_r)        state_nxt = ST_IDLE;
          else if (echo_r) state_nxt = ST_ECHO;
          else if (k_end)  state_nxt = ST_SEG;
          else             state_nxt = ST_MAC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      steps_r <= crs_pkg::STEPS_W'(crs_pkg::STEPS_RESET);
      ps_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid_w && cfg_ready_w) steps_r <= cfg_ch.segment_steps;
      if (state_r == ST_IDLE && in_fire && !start_spline) ps_r <= ps_r + 3'd1;
      if (out_fire && ol_r) ps_r <= (echo_r || nend_r) ? 3'd0 : 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!start_spline) begin
            wx_r[ps_r[1:0]] <= in_ch.point_x;
            wz_r[ps_r[1:0]] <= in_ch.point_z;
            wh_r[ps_r[1:0]] <= in_ch.heading_in;
          end else begin
            nx_r     <= in_ch.point_x;
            nz_r     <= in_ch.point_z;
            nh_r     <= in_ch.heading_in;
            nend_r   <= in_ch.path_end;
            r_r      <= rc;
            r2_r     <= r2_full[crs_pkg::R2_W-1:0];
            r3_r     <= r3_full[crs_pkg::FAC_W-1:0];
            echo_r   <= (ps_r < 3'd3);
            e_r      <= '0;
            ep_r     <= ps_r[1:0];
            k_r      <= '0;
            s_r      <= (ps_r == 3'd3) ? SEG_HEAD : SEG_MID;
            s_last_r <= in_ch.path_end ? SEG_TAIL : SEG_MID;
          end
        end
      end
      ST_ECHO: begin
        if (e_r == ep_r) begin
          ox_r <= nx_r; oz_r <= nz_r; oh_r <= nh_r; ol_r <= 1'b1;
        end else begin
          ox_r <= wx_r[e_r]; oz_r <= wz_r[e_r]; oh_r <= wh_r[e_r]; ol_r <= 1'b0;
        end
      end
      ST_SEG: begin
        coef_r.x <= mk_coef(qx[0], qx[1], qx[2], qx[3]);
        coef_r.z <= mk_coef(qz[0], qz[1], qz[2], qz[3]);
      end
      ST_WAIT: begin
        if (div_done && at_done) begin
          ox_r <= dq_x; oz_r <= dq_z; oh_r <= at_head; ol_r <= samp_last;
        end
      end
      ST_HOLD: begin
        if (out_fire) begin
          if (ol_r) begin
            if (!echo_r) begin
              wx_r[0] <= wx_r[1]; wx_r[1] <= wx_r[2]; wx_r[2] <= nx_r;
              wz_r[0] <= wz_r[1]; wz_r[1] <= wz_r[2]; wz_r[2] <= nz_r;
              wh_r[0] <= wh_r[1]; wh_r[1] <= wh_r[2]; wh_r[2] <= nh_r;
            end
          end else if (echo_r) begin
            e_r <= e_r + 2'd1;
          end else if (k_end) begin
            k_r <= '0;
            s_r <= s_r + 2'd1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
      end
      default: ol_r <= ol_r;
    endcase
  end

endmodule

// File: sv/crs_mac.sv
// Shared multiplier with four accumulators: position and derivative numerators.
// Depends on crs_pkg.
module crs_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                run,
  input  crs_pkg::coef_xz_t   coef,
  input  crs_pkg::fac_t       fac,
  output logic                done,
  output crs_pkg::mac_res_t   res
);

  logic [3:0]                          m_r;
  logic                                pv_r;
  logic signed [crs_pkg::COEF_W-1:0]   op_a;
  logic [crs_pkg::FAC_W-1:0]           op_b;
  crs_pkg::acc_sel_t                   sel;
  logic                                dbl;
  crs_pkg::acc_sel_t                   sel_r;
  logic                                dbl_r;
  logic signed [crs_pkg::PROD_W-1:0]   prod_r;
  logic signed [crs_pkg::ACC_W-1:0]    addend;

  always_comb begin
    op_a = coef.x.q1;
    op_b = fac.r3;
    sel  = crs_pkg::ACC_X;
    dbl  = 1'b0;
    case (m_r)
      4'd0:  begin op_a = coef.x.q1; op_b = fac.r3;    sel = crs_pkg::ACC_X;  dbl = 1'b1; end
      4'd1:  begin op_a = coef.x.a;  op_b = fac.kr2;   sel = crs_pkg::ACC_X;  end
      4'd2:  begin op_a = coef.x.b;  op_b = fac.k2r;   sel = crs_pkg::ACC_X;  end
      4'd3:  begin op_a = coef.x.c;  op_b = fac.k3;    sel = crs_pkg::ACC_X;  end
      4'd4:  begin op_a = coef.z.q1; op_b = fac.r3;    sel = crs_pkg::ACC_Z;  dbl = 1'b1; end
      4'd5:  begin op_a = coef.z.a;  op_b = fac.kr2;   sel = crs_pkg::ACC_Z;  end
      4'd6:  begin op_a = coef.z.b;  op_b = fac.k2r;   sel = crs_pkg::ACC_Z;  end
      4'd7:  begin op_a = coef.z.c;  op_b = fac.k3;    sel = crs_pkg::ACC_Z;  end
      4'd8:  begin op_a = coef.x.a;  op_b = fac.r2;    sel = crs_pkg::ACC_DX; end
      4'd9:  begin op_a = coef.x.b;  op_b = fac.kr_x2; sel = crs_pkg::ACC_DX; end
      4'd10: begin op_a = coef.x.c;  op_b = fac.k2_x3; sel = crs_pkg::ACC_DX; end
      4'd11: begin op_a = coef.z.a;  op_b = fac.r2;    sel = crs_pkg::ACC_DZ; end
      4'd12: begin op_a = coef.z.b;  op_b = fac.kr_x2; sel = crs_pkg::ACC_DZ; end
      4'd13: begin op_a = coef.z.c;  op_b = fac.k2_x3; sel = crs_pkg::ACC_DZ; end
      default: begin op_a = '0; op_b = '0; sel = crs_pkg::ACC_X; end
    endcase
  end

  assign addend = dbl_r ? (crs_pkg::ACC_W'(prod_r) <<< 1) : crs_pkg::ACC_W'(prod_r);
  assign done   = (m_r == 4'd15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r  <= '0;
      pv_r <= 1'b0;
    end else if (!run) begin
      m_r  <= '0;
      pv_r <= 1'b0;
    end else begin
      if (m_r != 4'd15) m_r <= m_r + 4'd1;
      pv_r <= (m_r < 4'(crs_pkg::TERMS));
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * $signed({1'b0, op_b});
    sel_r  <= sel;
    dbl_r  <= dbl;
    if (!run) begin
      res <= '0;
    end else if (pv_r) begin
      case (sel_r)
        crs_pkg::ACC_X:  res.nx <= res.nx + addend;
        crs_pkg::ACC_Z:  res.nz <= res.nz + addend;
        crs_pkg::ACC_DX: res.dx <= res.dx + addend;
        crs_pkg::ACC_DZ: res.dz <= res.dz + addend;
        default:         res.nx <= res.nx;
      endcase
    end
  end

endmodule

// File: sv/crs_div.sv
// Two-lane restoring divider, one quotient bit per cycle, truncating toward
// zero with 16-bit saturation. Depends on crs_pkg.
module crs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                run,
  input  logic signed [crs_pkg::ACC_W-1:0]    num_x,
  input  logic signed [crs_pkg::ACC_W-1:0]    num_z,
  input  logic [crs_pkg::DEN_W-1:0]           den,
  output logic                                done,
  output logic signed [crs_pkg::COORD_W-1:0]  q_x,
  output logic signed [crs_pkg::COORD_W-1:0]  q_z
);

  logic [crs_pkg::CNT_W-1:0]          cnt_r;
  logic [crs_pkg::MAG_W-1:0]          mag_r [2];
  logic [crs_pkg::MAG_W-1:0]          quo_r [2];
  logic [crs_pkg::REM_W-2:0]          rem_r [2];
  logic                               neg_r [2];
  logic signed [crs_pkg::ACC_W-1:0]   num   [2];
  logic signed [crs_pkg::ACC_W-1:0]   absn  [2];
  logic [crs_pkg::REM_W-1:0]          trial [2];
  logic [crs_pkg::REM_W-1:0]          diff  [2];
  logic                               fits  [2];
  logic signed [crs_pkg::MAG_W:0]     sq    [2];
  logic signed [crs_pkg::COORD_W-1:0] sat   [2];

  localparam logic signed [crs_pkg::MAG_W:0] SAT_HI = (1 <<< (crs_pkg::COORD_W - 1)) - 1;
  localparam logic signed [crs_pkg::MAG_W:0] SAT_LO = -(1 <<< (crs_pkg::COORD_W - 1));

  assign num[0] = num_x;
  assign num[1] = num_z;
  assign done   = (cnt_r == crs_pkg::CNT_W'(crs_pkg::MAG_W));

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      absn[l]  = num[l][crs_pkg::ACC_W-1] ? -num[l] : num[l];
      trial[l] = {rem_r[l], mag_r[l][crs_pkg::MAG_W-1]};
      fits[l]  = (trial[l] >= crs_pkg::REM_W'(den));
      diff[l]  = trial[l] - crs_pkg::REM_W'(den);
      sq[l]    = neg_r[l] ? -$signed({1'b0, quo_r[l]}) : $signed({1'b0, quo_r[l]});
      if (sq[l] > SAT_HI)      sat[l] = SAT_HI[crs_pkg::COORD_W-1:0];
      else if (sq[l] < SAT_LO) sat[l] = SAT_LO[crs_pkg::COORD_W-1:0];
      else                     sat[l] = sq[l][crs_pkg::COORD_W-1:0];
    end
  end

  assign q_x = sat[0];
  assign q_z = sat[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (!run) begin
      cnt_r <= '0;
    end else if (!done) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (!run) begin
        mag_r[l] <= absn[l][crs_pkg::MAG_W-1:0];
        quo_r[l] <= '0;
        rem_r[l] <= '0;
        neg_r[l] <= num[l][crs_pkg::ACC_W-1];
      end else if (!done) begin
        mag_r[l] <= mag_r[l] << 1;
        quo_r[l] <= {quo_r[l][crs_pkg::MAG_W-2:0], fits[l]};
        rem_r[l] <= fits[l] ? diff[l][crs_pkg::REM_W-2:0]
                            : trial[l][crs_pkg::REM_W-2:0];
      end
    end
  end

endmodule

// File: sv/crs_atan.sv
// Heading unit: normalizing shifter then a 20-step vectoring CORDIC, one
// step per cycle; gives pi/2 - atan2(vy, vx) in Q4.12. Depends on crs_pkg.
module crs_atan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               run,
  input  logic signed [crs_pkg::ACC_W-1:0]   vx,
  input  logic signed [crs_pkg::ACC_W-1:0]   vy,
  output logic                               done,
  output logic signed [crs_pkg::HEAD_W-1:0]  heading
);

  typedef enum logic [3:0] {
    AT_LOAD = 4'b0001,
    AT_NORM = 4'b0010,
    AT_ITER = 4'b0100,
    AT_DONE = 4'b1000
  } at_state_t;

  at_state_t                          state_r;
  logic [crs_pkg::NORM_W-1:0]         ax_r, ay_r;
  logic                               xneg_r, yneg_r, yzero_r;
  logic signed [crs_pkg::CORD_W-1:0]  x_r, y_r;
  logic signed [crs_pkg::ANG_W-1:0]   z_r;
  logic [4:0]                         i_r;
  logic signed [crs_pkg::ACC_W-1:0]   absx, absy;
  logic signed [crs_pkg::CORD_W-1:0]  ymag, ysh, dxs, dys;
  logic signed [crs_pkg::ANG_W-1:0]   ang, hsum;

  always_comb begin
    absx = vx[crs_pkg::ACC_W-1] ? -vx : vx;
    absy = vy[crs_pkg::ACC_W-1] ? -vy : vy;
    ymag = y_r[crs_pkg::CORD_W-1] ? -y_r : y_r;
    ysh  = ymag >>> i_r;
    dxs  = y_r[crs_pkg::CORD_W-1] ? -ysh : ysh;
    dys  = x_r >>> i_r;
    if (yzero_r) begin
      ang = xneg_r ? -crs_pkg::ANG_PI : '0;
    end else begin
      ang = xneg_r ? (crs_pkg::ANG_PI - z_r) : z_r;
      if (yneg_r) ang = -ang;
    end
    hsum    = crs_pkg::ANG_HALF_PI - ang + crs_pkg::ANG_ROUND;
    heading = hsum[crs_pkg::HEAD_W+7:8];
  end

  assign done = (state_r == AT_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n || !run) begin
      state_r <= AT_LOAD;
    end else begin
      case (state_r)
        AT_LOAD: state_r <= (vy == '0) ? AT_DONE : AT_NORM;
        AT_NORM: if ((ax_r[crs_pkg::NORM_W-1] | ay_r[crs_pkg::NORM_W-1])) state_r <= AT_ITER;
        AT_ITER: if (i_r == 5'(crs_pkg::CORDIC_STEPS - 1)) state_r <= AT_DONE;
        AT_DONE: state_r <= AT_DONE;
        default: state_r <= AT_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      AT_LOAD: begin
        ax_r    <= absx[crs_pkg::NORM_W-1:0];
        ay_r    <= absy[crs_pkg::NORM_W-1:0];
        xneg_r  <= vx[crs_pkg::ACC_W-1];
        yneg_r  <= vy[crs_pkg::ACC_W-1];
        yzero_r <= (vy == '0);
        i_r     <= '0;
        z_r     <= '0;
      end
      AT_NORM: begin
        if ((ax_r[crs_pkg::NORM_W-1] | ay_r[crs_pkg::NORM_W-1])) begin
          x_r <= crs_pkg::CORD_W'(ax_r);
          y_r <= crs_pkg::CORD_W'(ay_r);
        end else begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      AT_ITER: begin
        i_r <= i_r + 5'd1;
        if (!y_r[crs_pkg::CORD_W-1]) begin
          x_r <= x_r + dxs;
          y_r <= y_r - dys;
          z_r <= z_r + crs_pkg::atan_step(i_r);
        end else begin
          x_r <= x_r - dxs;
          y_r <= y_r + dys;
          z_r <= z_r - crs_pkg::atan_step(i_r);
        end
      end
      default: z_r <= z_r;
    endcase
  end

endmodule

// File: sv/crs_check.sv
// Port-level checks on the path sampler, bound to the top level.
// Depends on catmull_rom_path_spline.
module crs_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while a result waits");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped before transfer");

  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result right after input transfer");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input taken before run finished");

endmodule

bind catmull_rom_path_spline crs_check u_crs_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid_w),
  .in_ready  (in_ready_w),
  .out_valid (out_valid_w),
  .out_ready (out_ready_w),
  .out_last  (out_last_w)
);
